FILE: design/tss_pkg.sv
package tss_pkg;

  typedef enum logic [2:0] {
    ACT_CREATE     = 3'd0,
    ACT_TEARDOWN   = 3'd1,
    ACT_SCHEDULE   = 3'd2,
    ACT_SEM_INIT   = 3'd3,
    ACT_SEM_WAIT   = 3'd4,
    ACT_SEM_SIGNAL = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_FULL          = 3'd1,
    ST_NOT_FOUND     = 3'd2,
    ST_NONE_RUNNABLE = 3'd3,
    ST_BLOCKED       = 3'd4,
    ST_NO_CURRENT    = 3'd5,
    ST_IDS_EXHAUSTED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    SCAN_NEWEST,
    SCAN_READY,
    SCAN_WAKE
  } scan_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_REF_RD,
    C_REF_WAIT,
    C_SCAN,
    C_FIN,
    C_MID,
    C_COMMIT,
    C_OUT
  } ctrl_state_e;

  localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [2:0]  sem_index;
    logic [15:0] init_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_slot;
    logic [31:0] result_tid;
    logic        woke;
  } out_word_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    logic  rd_cur;
    logic  take_ref;
    logic  take_best;
    logic  clr;
    logic  commit;
    scan_e mode;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic best_vld;
  } sts_t;

endpackage

FILE: design/tss_ctrl.sv
module tss_ctrl
  import tss_pkg::*;
#(
  parameter int THREAD_SLOTS = 16,
  parameter int SLOT_W       = $clog2(THREAD_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        action_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o,
  output logic [SLOT_W-1:0] rd_addr_o
);

  localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(THREAD_SLOTS - 1);

  ctrl_state_e state_q, state_d;
  scan_e       mode_q, mode_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      mode_q  <= SCAN_NEWEST;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.mode  = mode_q;
    rd_addr_o   = cnt_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          if (action_i == ACT_SCHEDULE) begin
            if (sts_i.cur_valid) begin
              state_d = C_REF_RD;
            end else begin
              mode_d  = SCAN_NEWEST;
              state_d = C_SCAN;
            end
          end else if (action_i == ACT_SEM_SIGNAL) begin
            mode_d  = SCAN_WAKE;
            state_d = C_SCAN;
          end else begin
            state_d = C_COMMIT;
          end
        end
      end
      C_REF_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_cur = 1'b1;
        state_d      = C_REF_WAIT;
      end
      C_REF_WAIT: begin
        cmd_o.take_ref = 1'b1;
        mode_d         = SCAN_READY;
        cnt_d          = '0;
        state_d        = C_SCAN;
      end
      C_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.clr   = (cnt_q == '0);
        if (cnt_q == LastIdx) begin
          state_d = C_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      C_FIN: begin
        state_d = (mode_q == SCAN_NEWEST) ? C_MID : C_COMMIT;
      end
      C_MID: begin
        // newest thread stands in as current
        cmd_o.take_best = 1'b1;
        cnt_d           = '0;
        if (sts_i.best_vld) begin
          mode_d  = SCAN_READY;
          state_d = C_SCAN;
        end else begin
          state_d = C_COMMIT;
        end
      end
      C_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = C_OUT;
      end
      C_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

endmodule

FILE: design/tss_dp.sv
module tss_dp
  import tss_pkg::*;
#(
  parameter int THREAD_SLOTS = 16,
  parameter int NUM_SEMS     = 8,
  parameter int SEM_BITS     = 16,
  parameter int SLOT_W       = $clog2(THREAD_SLOTS),
  parameter int SEM_W        = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_word_t          in_word_i,
  input  cmd_t              cmd_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output sts_t              sts_o,
  output out_word_t         out_word_o
);

  localparam logic [SEM_BITS-1:0] SemMax = '1;

  logic [THREAD_SLOTS-1:0] used_q, used_d, ready_q, ready_d, blk_q, blk_d;
  logic [SLOT_W-1:0]       cur_q, cur_d;
  logic                    cur_vld_q, cur_vld_d;
  logic [31:0]             id_q, id_d;
  logic [SEM_BITS-1:0]     sem_val_q [NUM_SEMS];
  logic [SEM_BITS-1:0]     sem_wr_val;
  logic                    sem_we;

  logic [31:0]      tid_mem  [THREAD_SLOTS];
  logic [SEM_W-1:0] bsem_mem [THREAD_SLOTS];
  logic             tid_we, bsem_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [SEM_W-1:0] bsem_wr;

  in_word_t          item_q;
  logic [SEM_W-1:0]  sem_q;
  logic [SEM_W-1:0]  sem_in;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic [31:0]       rd_tid_q;
  logic [SEM_W-1:0]  rd_bsem_q;
  logic [SLOT_W-1:0] rd_addr;

  logic [31:0]       limit_q;
  logic              ref_ok_q;
  logic              a_vld_q, b_vld_q;
  logic [SLOT_W-1:0] a_idx_q, b_idx_q;
  logic [31:0]       a_tid_q, b_tid_q;
  logic              match_a, match_b;

  out_word_t out_q, out_d;

  // fold the semaphore index into range
  always_comb begin
    logic [2:0] r;
    r = in_word_i.sem_index;
    for (int k = 0; k < 8; k++) begin
      if (int'(r) >= NUM_SEMS) r = r - 3'(NUM_SEMS);
    end
    sem_in = SEM_W'(r);
  end

  assign rd_addr = cmd_i.rd_cur ? cur_q : rd_addr_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_tid_q  <= tid_mem[rd_addr];
      rd_bsem_q <= bsem_mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
    if (tid_we) tid_mem[wr_addr] <= id_q;
    if (bsem_we) bsem_mem[wr_addr] <= bsem_wr;
  end

  always_comb begin
    match_a = 1'b0;
    match_b = 1'b0;
    case (cmd_i.mode)
      SCAN_NEWEST: match_a = used_q[rd_idx_q];
      SCAN_READY: begin
        match_a = used_q[rd_idx_q] && ready_q[rd_idx_q];
        match_b = match_a && (rd_tid_q < limit_q);
      end
      SCAN_WAKE: match_a = used_q[rd_idx_q] && !ready_q[rd_idx_q] &&
                           blk_q[rd_idx_q] && (rd_bsem_q == sem_q);
      default: match_a = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q   <= in_word_i;
      sem_q    <= sem_in;
      ref_ok_q <= 1'b0;
    end
    if (cmd_i.take_ref) begin
      limit_q  <= rd_tid_q;
      ref_ok_q <= 1'b1;
    end
    if (cmd_i.take_best) begin
      limit_q  <= a_tid_q;
      ref_ok_q <= a_vld_q;
    end
    if (cmd_i.clr) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (match_a && (!a_vld_q || rd_tid_q > a_tid_q)) begin
        a_vld_q <= 1'b1;
        a_idx_q <= rd_idx_q;
        a_tid_q <= rd_tid_q;
      end
      if (match_b && (!b_vld_q || rd_tid_q > b_tid_q)) begin
        b_vld_q <= 1'b1;
        b_idx_q <= rd_idx_q;
        b_tid_q <= rd_tid_q;
      end
    end
    if (cmd_i.commit) out_q <= out_d;
  end

  always_comb begin
    logic [SLOT_W-1:0] free_idx;
    logic              free_ok;
    logic [SLOT_W-1:0] t_idx;
    logic [31:0]       init_w;
    used_d     = used_q;
    ready_d    = ready_q;
    blk_d      = blk_q;
    cur_d      = cur_q;
    cur_vld_d  = cur_vld_q;
    id_d       = id_q;
    sem_we     = 1'b0;
    sem_wr_val = sem_val_q[sem_q];
    tid_we     = 1'b0;
    bsem_we    = 1'b0;
    wr_addr    = cur_q;
    bsem_wr    = sem_q;
    out_d      = '0;
    free_idx   = '0;
    free_ok    = 1'b0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SLOT_W'(i);
        free_ok  = 1'b1;
      end
    end
    t_idx  = SLOT_W'(item_q.slot);
    init_w = 32'(item_q.init_value);
    if (cmd_i.commit) begin
      case (item_q.action)
        ACT_CREATE: begin
          if (!free_ok) begin
            out_d.status = ST_FULL;
          end else if (id_q == ID_MAX) begin
            out_d.status = ST_IDS_EXHAUSTED;
          end else begin
            used_d[free_idx]  = 1'b1;
            ready_d[free_idx] = 1'b1;
            blk_d[free_idx]   = 1'b0;
            tid_we            = 1'b1;
            bsem_we           = 1'b1;
            bsem_wr           = '0;
            wr_addr           = free_idx;
            id_d              = id_q + 32'd1;
            out_d.result_slot = 4'(free_idx);
            out_d.result_tid  = id_q;
          end
        end
        ACT_TEARDOWN: begin
          if (32'(item_q.slot) >= 32'(THREAD_SLOTS) || !used_q[t_idx]) begin
            out_d.status = ST_NOT_FOUND;
          end else begin
            used_d[t_idx]  = 1'b0;
            ready_d[t_idx] = 1'b0;
            blk_d[t_idx]   = 1'b0;
            if (cur_vld_q && cur_q == t_idx) cur_vld_d = 1'b0;
          end
        end
        ACT_SCHEDULE: begin
          if (!ref_ok_q || (!b_vld_q && !a_vld_q)) begin
            out_d.status = ST_NONE_RUNNABLE;
          end else if (b_vld_q) begin
            cur_d             = b_idx_q;
            cur_vld_d         = 1'b1;
            out_d.result_slot = 4'(b_idx_q);
            out_d.result_tid  = b_tid_q;
          end else begin
            cur_d             = a_idx_q;
            cur_vld_d         = 1'b1;
            out_d.result_slot = 4'(a_idx_q);
            out_d.result_tid  = a_tid_q;
          end
        end
        ACT_SEM_INIT: begin
          sem_we     = 1'b1;
          sem_wr_val = (init_w > 32'(SemMax)) ? SemMax : SEM_BITS'(init_w);
        end
        ACT_SEM_WAIT: begin
          if (sem_val_q[sem_q] != '0) begin
            sem_we     = 1'b1;
            sem_wr_val = sem_val_q[sem_q] - 1'b1;
          end else if (!cur_vld_q) begin
            out_d.status = ST_NO_CURRENT;
          end else begin
            ready_d[cur_q] = 1'b0;
            blk_d[cur_q]   = 1'b1;
            bsem_we        = 1'b1;
            out_d.status   = ST_BLOCKED;
          end
        end
        ACT_SEM_SIGNAL: begin
          if (sem_val_q[sem_q] != SemMax) begin
            sem_we     = 1'b1;
            sem_wr_val = sem_val_q[sem_q] + 1'b1;
          end
          if (a_vld_q) begin
            ready_d[a_idx_q]  = 1'b1;
            blk_d[a_idx_q]    = 1'b0;
            out_d.result_slot = 4'(a_idx_q);
            out_d.result_tid  = a_tid_q;
            out_d.woke        = 1'b1;
          end
        end
        default: out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      ready_q   <= '0;
      blk_q     <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      id_q      <= '0;
      rd_vld_q  <= 1'b0;
      for (int s = 0; s < NUM_SEMS; s++) sem_val_q[s] <= '0;
    end else begin
      used_q    <= used_d;
      ready_q   <= ready_d;
      blk_q     <= blk_d;
      cur_q     <= cur_d;
      cur_vld_q <= cur_vld_d;
      id_q      <= id_d;
      rd_vld_q  <= cmd_i.rd_en;
      if (sem_we) sem_val_q[sem_q] <= sem_wr_val;
    end
  end

  assign sts_o.cur_valid = cur_vld_q;
  assign sts_o.best_vld  = a_vld_q;
  assign out_word_o      = out_q;

endmodule

FILE: design/thread_scheduler_with_semaphores.sv
// Channel  Valid        Stall         Word
// in       in_valid_i   in_stall_o    in_word_i  (action, slot, sem_index, init_value)
// out      out_valid_o  out_stall_i   out_word_o (status, result_slot, result_tid, woke)
//
// One request at a time; a request is taken only while no result is pending.
// Create, teardown, init and wait need no slot walk. Signal and schedule walk the slots over
// the single read port of the id memory; schedule with no current walks them twice, once if empty.
// Reset clears the thread flags, the current thread, the id counter and the counts.
// A stalled result holds on out_word_o; input stays stalled until it is taken.
module thread_scheduler_with_semaphores
  import tss_pkg::*;
#(
  parameter int THREAD_SLOTS = 16,
  parameter int NUM_SEMS     = 8,
  parameter int SEM_BITS     = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int SlotW = $clog2(THREAD_SLOTS);

  cmd_t             cmd;
  sts_t             sts;
  logic [SlotW-1:0] rd_addr;

  tss_ctrl #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .SLOT_W      (SlotW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (in_word_i.action),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  tss_dp #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .NUM_SEMS    (NUM_SEMS),
    .SEM_BITS    (SEM_BITS),
    .SLOT_W      (SlotW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .sts_o     (sts),
    .out_word_o(out_word_o)
  );

endmodule

FILE: design/tss_checker.sv
module tss_checker
  import tss_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken with result pending");

  a_woke_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.woke |-> out_word_o.status == ST_OK)
    else $error("wake with error status");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |->
      out_word_o.result_slot == '0 && out_word_o.result_tid == '0)
    else $error("error result carries a thread");

endmodule

bind thread_scheduler_with_semaphores tss_checker u_tss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

FILE: test/thread_scheduler_with_semaphores_test.sv
`timescale 1ns / 1ps

module thread_scheduler_with_semaphores_test;
  import tss_pkg::*;

  localparam int NSLOT = 16;
  localparam int NSEM = 8;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  thread_scheduler_with_semaphores u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // predictor state
  logic        used_q [NSLOT];
  logic        rdy_q [NSLOT];
  logic        blk_q [NSLOT];
  logic [2:0]  blk_sem_q [NSLOT];
  logic [31:0] tid_q [NSLOT];
  logic [3:0]  cur_slot_q;
  logic        cur_valid_q;
  logic [31:0] next_id_q;
  logic [15:0] count_q [NSEM];

  in_word_t  request_q [$];
  out_word_t reply_q [$];
  int        errors = 0;
  bit        hold_off;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic out_word_t mk(status_e st, int s, logic [31:0] t, int w);
    out_word_t r;
    r.status = st;
    r.result_slot = 4'(s);
    r.result_tid = t;
    r.woke = 1'(w);
    return r;
  endfunction

  function automatic int newest_runnable(logic [31:0] lim, bit all);
    int b;
    b = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!used_q[i] || !rdy_q[i]) continue;
      if (!all && tid_q[i] >= lim) continue;
      if (b < 0 || tid_q[i] > tid_q[b]) b = i;
    end
    return b;
  endfunction

  function automatic out_word_t run_request(in_word_t w);
    out_word_t r;
    int f;
    int rf;
    logic [2:0] sm;
    r = mk(ST_OK, 0, 0, 0);
    sm = w.sem_index;
    case (w.action)
      ACT_CREATE: begin
        f = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!used_q[i]) f = i;
        if (f < 0) r = mk(ST_FULL, 0, 0, 0);
        else if (next_id_q == ID_MAX) r = mk(ST_IDS_EXHAUSTED, 0, 0, 0);
        else begin
          used_q[f] = 1; rdy_q[f] = 1; blk_q[f] = 0; blk_sem_q[f] = 0;
          tid_q[f] = next_id_q;
          next_id_q++;
          r = mk(ST_OK, f, tid_q[f], 0);
        end
      end
      ACT_TEARDOWN: begin
        if (!used_q[w.slot]) r = mk(ST_NOT_FOUND, 0, 0, 0);
        else begin
          used_q[w.slot] = 0; rdy_q[w.slot] = 0; blk_q[w.slot] = 0;
          if (cur_valid_q && cur_slot_q == w.slot) cur_valid_q = 0;
        end
      end
      ACT_SCHEDULE: begin
        rf = -1;
        if (cur_valid_q) rf = int'(cur_slot_q);
        else
          for (int i = 0; i < NSLOT; i++)
            if (used_q[i] && (rf < 0 || tid_q[i] > tid_q[rf])) rf = i;
        if (rf < 0) r = mk(ST_NONE_RUNNABLE, 0, 0, 0);
        else begin
          f = newest_runnable(tid_q[rf], 0);
          if (f < 0) f = newest_runnable(0, 1);
          if (f < 0) r = mk(ST_NONE_RUNNABLE, 0, 0, 0);
          else begin
            cur_slot_q = 4'(f);
            cur_valid_q = 1;
            r = mk(ST_OK, f, tid_q[f], 0);
          end
        end
      end
      ACT_SEM_INIT: count_q[sm] = w.init_value;
      ACT_SEM_WAIT: begin
        if (count_q[sm] != 0) count_q[sm]--;
        else if (!cur_valid_q) r = mk(ST_NO_CURRENT, 0, 0, 0);
        else begin
          rdy_q[cur_slot_q] = 0; blk_q[cur_slot_q] = 1; blk_sem_q[cur_slot_q] = sm;
          r = mk(ST_BLOCKED, 0, 0, 0);
        end
      end
      ACT_SEM_SIGNAL: begin
        if (count_q[sm] != COUNT_MAX) count_q[sm]++;
        f = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (!used_q[i] || rdy_q[i] || !blk_q[i] || blk_sem_q[i] != sm) continue;
          if (f < 0 || tid_q[i] > tid_q[f]) f = i;
        end
        if (f >= 0) begin
          rdy_q[f] = 1; blk_q[f] = 0;
          r = mk(ST_OK, f, tid_q[f], 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t req(int a, int s, int sm, int v);
    in_word_t w;
    w.action = 3'(a);
    w.slot = 4'(s);
    w.sem_index = 3'(sm);
    w.init_value = 16'(v);
    return w;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        reply_q.push_back(run_request(in_word_i));
        if (request_q.size() > 0 && gap_len() == 0) begin
          in_word_i <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          send_gap <= gap_len();
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (request_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= request_q.pop_front();
        end
      end
    end
  end

  // monitor
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t unexpected word %p", $time, out_word_o);
          errors++;
        end else begin
          out_word_t e;
          e = reply_q.pop_front();
          if (out_word_o.status !== e.status)
            $display("%0t status exp %0d got %0d", $time, e.status, out_word_o.status);
          if (out_word_o.result_slot !== e.result_slot)
            $display("%0t slot exp %0d got %0d", $time, e.result_slot,
                     out_word_o.result_slot);
          if (out_word_o.result_tid !== e.result_tid)
            $display("%0t tid exp %0h got %0h", $time, e.result_tid,
                     out_word_o.result_tid);
          if (out_word_o.woke !== e.woke)
            $display("%0t woke exp %0b got %0b", $time, e.woke, out_word_o.woke);
          if (out_word_o !== e) errors++;
        end
      end
      if (hold_off) out_stall_i <= 1'b1;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        recv_gap <= gap_len();
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_random(int n);
    int p;
    int a;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      // keep the table mostly half full so that most requests find work
      if (p < 22) a = ACT_CREATE;
      else if (p < 36) a = ACT_TEARDOWN;
      else if (p < 56) a = ACT_SCHEDULE;
      else if (p < 64) a = ACT_SEM_INIT;
      else if (p < 80) a = ACT_SEM_WAIT;
      else if (p < 97) a = ACT_SEM_SIGNAL;
      else a = $urandom_range(6, 7);
      request_q.push_back(req(a, $urandom_range(0, 15), $urandom_range(0, 7),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 2)));
    end
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_valid_i || reply_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    hold_off = 0;
    for (int i = 0; i < NSLOT; i++) begin
      used_q[i] = 0; rdy_q[i] = 0; blk_q[i] = 0; blk_sem_q[i] = 0; tid_q[i] = 0;
    end
    for (int i = 0; i < NSEM; i++) count_q[i] = 0;
    cur_slot_q = 0; cur_valid_q = 0; next_id_q = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table cases, then fill, block, wake, saturate
    request_q.push_back(req(ACT_SCHEDULE, 0, 0, 0));
    request_q.push_back(req(ACT_TEARDOWN, 15, 0, 0));
    request_q.push_back(req(ACT_SEM_WAIT, 0, 7, 0));
    request_q.push_back(req(ACT_SEM_SIGNAL, 0, 7, 0));
    request_q.push_back(req(ACT_SEM_WAIT, 0, 7, 0));
    for (int i = 0; i < 17; i++) request_q.push_back(req(ACT_CREATE, 0, 0, 0));
    request_q.push_back(req(ACT_SCHEDULE, 0, 0, 0));
    request_q.push_back(req(ACT_SEM_WAIT, 0, 2, 0));
    request_q.push_back(req(ACT_SEM_INIT, 0, 5, 16'hFFFF));
    request_q.push_back(req(ACT_SEM_SIGNAL, 0, 5, 16'h5555));
    request_q.push_back(req(ACT_SEM_SIGNAL, 0, 2, 0));
    request_q.push_back(req(6, 10, 5, 16'hAAAA));
    request_q.push_back(req(7, 5, 2, 0));
    request_q.push_back(req(ACT_SCHEDULE, 0, 0, 0));
    drain();

    // sender pauses until every result is back, then tears down the newest thread
    request_q.push_back(req(ACT_TEARDOWN, 15, 0, 0));
    request_q.push_back(req(ACT_SCHEDULE, 0, 0, 0));
    request_q.push_back(req(ACT_TEARDOWN, 0, 0, 0));
    push_random(400);

    // receiver holds off while the sender keeps offering
    repeat (200) @(posedge clk_i);
    hold_off = 1;
    repeat (600) @(posedge clk_i);
    hold_off = 0;
    push_random(1030);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
design/tss_pkg.sv
design/tss_ctrl.sv
design/tss_dp.sv
design/thread_scheduler_with_semaphores.sv
design/tss_checker.sv
test/thread_scheduler_with_semaphores_test.sv
